@@ hw/rtl/bchd_pkg.sv @@
// shared types and codes for the bch dimension block
// no dependencies; imported by bchd_screen and bch_dimension_from_cosets
package bchd_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DEGREE   = 2'd1,
    ST_CAPACITY = 2'd2,
    ST_LENGTH   = 2'd3
  } status_e;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_CHECK = 6'b000100,
    S_WAIT  = 6'b001000,
    S_WALK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

endpackage

@@ hw/rtl/bchd_ram.sv @@
// generic single-port ram with registered read data
// no dependencies
module bchd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read, read-before-write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bchd_screen.sv @@
// parameter screening: status code, code length and walk limits for one beat
// depends on bchd_pkg
module bchd_screen import bchd_pkg::*; #(
  parameter int MAX_M = 10
) (
  input  logic [4:0]                 field_degree_i,
  input  logic [15:0]                correct_capacity_i,
  output status_e                    status_o,
  output logic [MAX_M-1:0]           len_o,
  output logic [MAX_M-1:0]           lim_o,
  output logic [$clog2(MAX_M)-1:0]   mm1_o
);

  logic [16:0] len_full;
  logic [16:0] twice_t;

  assign len_full = (17'd1 << field_degree_i) - 17'd1;
  assign twice_t  = {correct_capacity_i, 1'b0};

  // range checks in priority order
  always_comb begin
    if (field_degree_i == 5'd0 || {1'b0, field_degree_i} > 6'(MAX_M)) begin
      status_o = ST_DEGREE;
    end else if (correct_capacity_i == 16'd0) begin
      status_o = ST_CAPACITY;
    end else if (twice_t >= len_full) begin
      status_o = ST_LENGTH;
    end else begin
      status_o = ST_OK;
    end
  end

  assign len_o = len_full[MAX_M-1:0];
  assign lim_o = twice_t[MAX_M-1:0];
  assign mm1_o = $clog2(MAX_M)'(field_degree_i - 5'd1);

endmodule

@@ hw/rtl/bch_dimension_from_cosets.sv @@
// top level: dimension and redundancy of a primitive narrow-sense binary bch code
// depends on bchd_pkg, bchd_screen, bchd_ram
//
// usage
// - input channel (in_valid_i / in_ready_o) takes one beat of field_degree_i
//   and correct_capacity_i; in_ready_o is high only while the sequencer idles
// - output channel (out_valid_o / out_ready_i) returns code_dimension_o,
//   redundancy_o and status_o, one beat per input beat, in order
// - a beat with a bad status goes from idle straight to the done state
// - a good beat runs a clearing pass over all 2^MAX_M words of the coverage ram,
//   then, for each exponent 1..2t, a ram read and a wait for the registered
//   data, plus one write per coset member walked when that exponent is not
//   yet covered
// - the single-port ram and rotate-by-one unit pace each pass word by word
// - the result sits in an output register; the next beat is accepted while
//   it waits, and a stalled receiver holds the sequencer in the done state
//   only after the following item completes
// - reset clears the sequencer and the output valid; the ram needs no reset
//   since every good beat clears it first
module bch_dimension_from_cosets import bchd_pkg::*; #(
  parameter int MAX_M = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  field_degree_i,
  input  logic [15:0] correct_capacity_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  code_dimension_o,
  output logic [9:0]  redundancy_o,
  output logic [1:0]  status_o
);

  localparam int AW    = MAX_M;
  localparam int DEPTH = 1 << MAX_M;
  localparam int IW    = $clog2(MAX_M);

  state_e           state_q, state_d;
  status_e          status_q, status_d, scr_status;
  logic [AW-1:0]    len_q, len_d, scr_len;
  logic [AW-1:0]    lim_q, lim_d, scr_lim;
  logic [IW-1:0]    mm1_q, mm1_d, scr_mm1;
  logic [AW-1:0]    exp_q, exp_d;
  logic [AW-1:0]    cur_q, cur_d;
  logic [AW-1:0]    red_q, red_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [AW-1:0]    rot;
  logic [AW-1:0]    dim;
  logic             out_valid_q, out_valid_d;
  logic [9:0]       out_dim_q, out_dim_d;
  logic [9:0]       out_red_q, out_red_d;
  status_e          out_st_q, out_st_d;
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic             ram_wdata;
  logic             ram_rdata;
  logic             in_fire;
  logic             out_load;

  bchd_screen #(.MAX_M(MAX_M)) u_screen (
    .field_degree_i    (field_degree_i),
    .correct_capacity_i(correct_capacity_i),
    .status_o          (scr_status),
    .len_o             (scr_len),
    .lim_o             (scr_lim),
    .mm1_o             (scr_mm1)
  );

  bchd_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // doubling mod n: rotate left by one within m bits
  assign rot = ({cur_q[AW-2:0], 1'b0} & len_q) | AW'(cur_q[mm1_q]);

  assign dim = len_q - red_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    len_d     = len_q;
    lim_d     = lim_q;
    mm1_d     = mm1_q;
    exp_d     = exp_q;
    cur_d     = cur_q;
    red_d     = red_q;
    clr_d     = clr_q;
    ram_we    = 1'b0;
    ram_addr  = exp_q;
    ram_wdata = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          status_d = scr_status;
          len_d    = scr_len;
          lim_d    = scr_lim;
          mm1_d    = scr_mm1;
          red_d    = '0;
          clr_d    = '0;
          exp_d    = AW'(1);
          state_d  = (scr_status == ST_OK) ? S_CLEAR : S_DONE;
        end
      end
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        ram_addr = exp_q;
        state_d  = S_WAIT;
      end
      S_WAIT: begin
        if (ram_rdata) begin
          if (exp_q == lim_q) begin
            state_d = S_DONE;
          end else begin
            exp_d   = exp_q + AW'(1);
            state_d = S_CHECK;
          end
        end else begin
          cur_d   = exp_q;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        ram_we    = 1'b1;
        ram_addr  = cur_q;
        ram_wdata = 1'b1;
        red_d     = red_q + AW'(1);
        cur_d     = rot;
        if (rot == exp_q) begin
          if (exp_q == lim_q) begin
            state_d = S_DONE;
          end else begin
            exp_d   = exp_q + AW'(1);
            state_d = S_CHECK;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_dim_d   = out_dim_q;
    out_red_d   = out_red_q;
    out_st_d    = out_st_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_st_d    = status_q;
      if (status_q == ST_OK) begin
        out_dim_d = 10'(dim);
        out_red_d = 10'(red_q);
      end else begin
        out_dim_d = '0;
        out_red_d = '0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    len_q     <= len_d;
    lim_q     <= lim_d;
    mm1_q     <= mm1_d;
    exp_q     <= exp_d;
    cur_q     <= cur_d;
    red_q     <= red_d;
    clr_q     <= clr_d;
    out_dim_q <= out_dim_d;
    out_red_q <= out_red_d;
    out_st_q  <= out_st_d;
  end

  assign out_valid_o      = out_valid_q;
  assign code_dimension_o = out_dim_q;
  assign redundancy_o     = out_red_q;
  assign status_o         = out_st_q;

endmodule
